[design/lqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqs_pkg - shared types and constants of the link quality sampler
// Beat types, register indexes, reset values and divider handshake structs.
// ----------------------------------------------------------------------------
package lqs_pkg;

  // time width default
  localparam int TIME_BITS_DEF = 32;

  // configuration port
  localparam int CFG_W = 16;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_SAMPLE_PERIOD   = 3'd0;
  localparam logic [IDX_W-1:0] REG_STALE_PERIOD    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEFAULT_FEC_K   = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEFAULT_FEC_N   = 3'd3;
  localparam logic [IDX_W-1:0] REG_BACKJUMP_MARGIN = 3'd4;

  // register reset values
  localparam logic [15:0] SAMPLE_PERIOD_RST   = 16'd300;
  localparam logic [15:0] STALE_PERIOD_RST    = 16'd2000;
  localparam logic [7:0]  DEFAULT_FEC_K_RST   = 8'd6;
  localparam logic [7:0]  DEFAULT_FEC_N_RST   = 8'd12;
  localparam logic [15:0] BACKJUMP_MARGIN_RST = 16'd64;

  // q1.15 unity
  localparam logic [15:0] Q_ONE = 16'd32768;

  // shared divider widths
  localparam int DIV_DEND_W = 32;
  localparam int DIV_SOR_W  = 40;
  localparam int DIV_CNT_W  = $clog2(DIV_DEND_W + 1);

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  fec_k_in;
    logic [7:0]  fec_n_in;
    logic [15:0] received_count;
    logic [31:0] last_packet_index;
    logic        stats_present;
    logic [15:0] sent_rate;
    logic [15:0] arrived_rate;
  } item_t;

  typedef struct packed {
    logic [15:0] video_quality;
    logic [15:0] rc_quality;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_DEND_W-1:0] dividend;
    logic [DIV_SOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIV_DEND_W-1:0] quotient;
  } div_rsp_t;

  // truncated quotient clamped to unity
  function automatic logic [15:0] clamp_q15(input logic [DIV_DEND_W-1:0] q);
    logic [15:0] r;
    if (q > DIV_DEND_W'(Q_ONE)) begin
      r = Q_ONE;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

[design/lqs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqs_div - shared restoring divider
// One quotient bit per cycle; a start pulse loads operands, done pulses once.
// ----------------------------------------------------------------------------
module lqs_div
  import lqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_SOR_W-1:0]  rem;
  logic [DIV_DEND_W-1:0] quo;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  busy;
  logic                  done;
  logic [DIV_SOR_W:0]    trial;

  // shift in the next dividend bit
  assign trial = {rem, quo[DIV_DEND_W-1]};

  // iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (trial >= {1'b0, req.divisor}) begin
          rem <= DIV_SOR_W'(trial - {1'b0, req.divisor});
          quo <= {quo[DIV_DEND_W-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_SOR_W-1:0];
          quo <= {quo[DIV_DEND_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        rem  <= '0;
        quo  <= req.dividend;
        cnt  <= DIV_CNT_W'(DIV_DEND_W);
        busy <= 1'b1;
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[design/link_quality_sampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_quality_sampler - video and rc link quality sampler
// Tracks the fec block window and samples delivery ratios in q1.15.
// ----------------------------------------------------------------------------
// One update beat gives one result beat with the current video and rc
// qualities (q1.15, 32768 is 1.0). The block takes one update at a time: it
// drops item_ready after an accepted beat and raises it again once the result
// sits in the output register, so a waiting result does not hold off the next
// update. With the output register free, the time from one accept to the next
// possible accept is set by the one shared restoring divider, which loads its
// operands, steps through every dividend bit and hands over the quotient: it
// runs for the block index when n is nonzero, for the video ratio when a
// sample is due (after a registered blocks-times-n multiply), and for the rc
// ratio when an rc sample is due and packets were sent. Configuration writes
// take effect at once and are meant to happen while no update is in flight.
module link_quality_sampler
  import lqs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_ready,
  output result_t          result
);

  typedef logic [TIME_BITS-1:0] tm_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BDIV,
    S_VIDEO,
    S_MUL,
    S_VGO,
    S_VDIV,
    S_RC,
    S_RDIV,
    S_FINISH
  } state_t;

  // configuration registers
  logic [15:0] sample_period;
  logic [15:0] stale_period;
  logic [7:0]  default_fec_k;
  logic [7:0]  default_fec_n;
  logic [15:0] backjump_margin;

  // tracking state
  logic        video_started;
  logic [7:0]  active_fec_k;
  logic [7:0]  active_fec_n;
  logic [15:0] window_start_count;
  logic [15:0] last_seen_count;
  logic [31:0] window_start_block;
  logic [31:0] highest_block;
  tm_t         last_video_sample_time;
  tm_t         last_video_data_time;
  tm_t         last_rc_sample_time;
  logic [15:0] video_quality_reg;
  logic [15:0] rc_quality_reg;

  // per-update working registers
  state_t      state;
  item_t       itm;
  logic [7:0]  eff_k;
  logic [7:0]  eff_n;
  logic [31:0] block;
  logic [31:0] completed_reg;
  logic [15:0] got_reg;
  logic [DIV_SOR_W-1:0] product;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // combinational decisions
  logic [7:0]  k_in;
  logic [7:0]  n_in;
  tm_t         now_w;
  logic        fec_change;
  logic        rollover;
  logic        backjump;
  logic [31:0] high_new;
  logic        cnt_moved;
  tm_t         data_time_new;
  logic        stale_new;
  logic        stale_old;
  logic        video_due;
  logic        rc_due;
  logic [31:0] completed;
  logic [15:0] got;
  logic [15:0] rc_min;
  logic [DIV_SOR_W-1:0] prod_c;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period   <= SAMPLE_PERIOD_RST;
      stale_period    <= STALE_PERIOD_RST;
      default_fec_k   <= DEFAULT_FEC_K_RST;
      default_fec_n   <= DEFAULT_FEC_N_RST;
      backjump_margin <= BACKJUMP_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_PERIOD:   sample_period   <= cfg_data[15:0];
        REG_STALE_PERIOD:    stale_period    <= cfg_data[15:0];
        REG_DEFAULT_FEC_K:   default_fec_k   <= cfg_data[7:0];
        REG_DEFAULT_FEC_N:   default_fec_n   <= cfg_data[7:0];
        REG_BACKJUMP_MARGIN: backjump_margin <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // effective fec pair of the incoming beat
  always_comb begin
    k_in = (item.fec_k_in != 8'd0) ? item.fec_k_in : default_fec_k;
    n_in = (item.fec_n_in >= k_in) ? item.fec_n_in : default_fec_n;
  end

  // video and rc decisions on the held beat
  always_comb begin
    now_w         = TIME_BITS'(itm.now_ms);
    fec_change    = !video_started || (eff_k != active_fec_k) || (eff_n != active_fec_n);
    rollover      = (itm.received_count == 16'd0) && (itm.last_packet_index == 32'd0) &&
                    (last_seen_count != 16'd0);
    backjump      = ({1'b0, block} + {17'd0, backjump_margin}) < {1'b0, highest_block};
    high_new      = (block > highest_block) ? block : highest_block;
    cnt_moved     = itm.received_count != last_seen_count;
    data_time_new = cnt_moved ? now_w : last_video_data_time;
    stale_new     = tm_t'(now_w - data_time_new) >= tm_t'(stale_period);
    stale_old     = tm_t'(now_w - last_video_data_time) >= tm_t'(stale_period);
    video_due     = tm_t'(now_w - last_video_sample_time) >= tm_t'(sample_period);
    rc_due        = tm_t'(now_w - last_rc_sample_time) >= tm_t'(sample_period);
    completed     = high_new - window_start_block;
    got           = itm.received_count - window_start_count;
    rc_min        = (itm.arrived_rate < itm.sent_rate) ? itm.arrived_rate : itm.sent_rate;
  end

  // expected packets: completed blocks times n
  assign prod_c = {8'd0, completed_reg} * {32'd0, eff_n};

  assign item_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= S_IDLE;
      result_valid           <= 1'b0;
      div_req.start          <= 1'b0;
      video_started          <= 1'b0;
      active_fec_k           <= '0;
      active_fec_n           <= '0;
      window_start_count     <= '0;
      last_seen_count        <= '0;
      window_start_block     <= '0;
      highest_block          <= '0;
      last_video_sample_time <= '0;
      last_video_data_time   <= '0;
      last_rc_sample_time    <= '0;
      video_quality_reg      <= '0;
      rc_quality_reg         <= '0;
    end else begin
      div_req.start <= 1'b0;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        // take an update beat and, when n is nonzero, start the block index division
        S_IDLE: begin
          if (item_valid) begin
            itm   <= item;
            eff_k <= k_in;
            eff_n <= n_in;
            if (n_in != 8'd0) begin
              div_req.start    <= 1'b1;
              div_req.dividend <= item.last_packet_index;
              div_req.divisor  <= DIV_SOR_W'(n_in);
              state            <= S_BDIV;
            end else begin
              block <= '0;
              state <= S_VIDEO;
            end
          end
        end
        S_BDIV: begin
          if (div_rsp.done) begin
            block <= div_rsp.quotient;
            state <= S_VIDEO;
          end
        end
        // window tracking; a rollover glitch takes priority over a back-jump
        S_VIDEO: begin
          state <= S_RC;
          if (fec_change || (backjump && !rollover)) begin
            window_start_count     <= itm.received_count;
            last_seen_count        <= itm.received_count;
            window_start_block     <= block;
            highest_block          <= block;
            active_fec_k           <= eff_k;
            active_fec_n           <= eff_n;
            last_video_sample_time <= now_w;
            last_video_data_time   <= now_w;
            video_started          <= 1'b1;
            if (!fec_change) begin
              video_quality_reg <= '0;
            end
          end else if (rollover) begin
            if (stale_old) begin
              video_quality_reg <= '0;
            end
          end else begin
            highest_block <= high_new;
            if (cnt_moved) begin
              last_seen_count      <= itm.received_count;
              last_video_data_time <= now_w;
            end
            if (stale_new) begin
              video_quality_reg <= '0;
            end
            if (video_due && (completed != 32'd0)) begin
              completed_reg          <= completed;
              got_reg                <= got;
              window_start_count     <= itm.received_count;
              window_start_block     <= high_new;
              last_video_sample_time <= now_w;
              state                  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          product <= prod_c;
          state   <= S_VGO;
        end
        S_VGO: begin
          div_req.start    <= 1'b1;
          div_req.dividend <= {1'b0, got_reg, 15'd0};
          div_req.divisor  <= product;
          state            <= S_VDIV;
        end
        S_VDIV: begin
          if (div_rsp.done) begin
            video_quality_reg <= clamp_q15(div_rsp.quotient);
            state             <= S_RC;
          end
        end
        // rc sampling
        S_RC: begin
          state <= S_FINISH;
          if (!itm.stats_present) begin
            rc_quality_reg <= '0;
          end else if (rc_due) begin
            last_rc_sample_time <= now_w;
            if (itm.sent_rate == 16'd0) begin
              rc_quality_reg <= Q_ONE;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= {1'b0, rc_min, 15'd0};
              div_req.divisor  <= DIV_SOR_W'(itm.sent_rate);
              state            <= S_RDIV;
            end
          end
        end
        S_RDIV: begin
          if (div_rsp.done) begin
            rc_quality_reg <= clamp_q15(div_rsp.quotient);
            state          <= S_FINISH;
          end
        end
        // load the output register once it is free
        S_FINISH: begin
          if (!result_valid || result_ready) begin
            result.video_quality <= video_quality_reg;
            result.rc_quality    <= rc_quality_reg;
            result_valid         <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lqs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // checks
  a_quality_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.video_quality <= Q_ONE) && (result.rc_quality <= Q_ONE))
    else $error("quality above unity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("ready while an update is in flight");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_BDIV) || (state == S_VDIV) || (state == S_RDIV))
    else $error("divider done with no division pending");

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule
